// File: rtl/core/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg: shared constants for the swept circle collision core
// Configuration register indexes, register widths and reset values.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int SKIN_W = 31;
  localparam int LIM_W  = 16;
  localparam int CFG_DW = 31;
  localparam int CFG_IW = 2;

  typedef logic [CFG_IW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SKIN_MARGIN  = 2'd0;
  localparam cfg_idx_t CFG_ZERO_SPEED   = 2'd1;

  localparam logic [SKIN_W-1:0] SKIN_RST  = '0;
  localparam logic [LIM_W-1:0]  LIMIT_RST = 16'd1;

endpackage

// File: rtl/core/swept_circle_collision_core.sv
// ----------------------------------------------------------------------------
// swept_circle_collision_core: swept circle against still circle test
// Solves the entry quadratic in fixed point and reports hit, time of impact
// and the unnormalized contact normal for one circle pair per transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | mover, target, dir, speed
//  out_    | output    | out_valid / out_ready| hit, impact_time, normal
//  cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle is accepted unless the output is stalled. The datapath
// runs through the digit-serial square root (2*W+1 stages) and the two restoring
// dividers (one quotient bit per stage).
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module swept_circle_collision_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  swc_pkg::cfg_idx_t                 cfg_index,
  input  logic [swc_pkg::CFG_DW-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     in_mover_x,
  input  logic signed [COORD_WIDTH-1:0]     in_mover_y,
  input  logic        [COORD_WIDTH-2:0]     in_mover_radius,
  input  logic signed [COORD_WIDTH-1:0]     in_target_x,
  input  logic signed [COORD_WIDTH-1:0]     in_target_y,
  input  logic        [COORD_WIDTH-2:0]     in_target_radius,
  input  logic signed [COORD_WIDTH-1:0]     in_dir_x,
  input  logic signed [COORD_WIDTH-1:0]     in_dir_y,
  input  logic signed [COORD_WIDTH-1:0]     in_speed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic signed [COORD_WIDTH-1:0]     out_impact_time,
  output logic signed [COORD_WIDTH-1:0]     out_normal_x,
  output logic signed [COORD_WIDTH-1:0]     out_normal_y
);
  import swc_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int VW   = W + 1;
  localparam int AW   = 2 * W;
  localparam int HW   = 2 * W + 2;
  localparam int CW   = 2 * W + 3;
  localparam int HM   = 2 * W + 1;
  localparam int CM   = 2 * W + 2;
  localparam int SP   = W + 1;
  localparam int DMW  = 4 * W + 2;
  localparam int NDIG = DMW / 2;
  localparam int RTW  = 2 * W + 1;
  localparam int RMW  = 2 * W + 4;
  localparam int TW   = 2 * W + 3;
  localparam int TM   = 2 * W + 2;
  localparam int NW   = TM + F;
  localparam int SMAG = (W - 1 > SKIN_W) ? W - 1 : SKIN_W;
  localparam int QB   = SMAG + 1;
  localparam int DVW  = (NW > AW + QB) ? NW : AW + QB;
  localparam int SW   = QB + 2;
  localparam int SRW  = SMAG + 1;
  localparam int INW  = SMAG + F;
  localparam int IQB  = W;
  localparam int IDW  = (INW > W + IQB) ? INW : W + IQB;
  localparam int PW   = VW + SRW;
  localparam int NSW  = ((PW - F > VW) ? PW - F : VW) + 1;
  localparam int LCW  = (W > LIM_W) ? W : LIM_W;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic        [W-1:0]  spm;
    logic                 nohit;
  } side_t;

  function automatic logic signed [W-1:0] sat_w(input logic signed [NSW-1:0] v);
    logic signed [W-1:0] r;
    if (v > NSW'(WMAX)) begin
      r = WMAX;
    end else if (v < NSW'(WMIN)) begin
      r = WMIN;
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [SKIN_W-1:0] cfg_skin_r;
  logic [LIM_W-1:0]  cfg_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_skin_r  <= SKIN_RST;
      cfg_limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SKIN_MARGIN) begin
        cfg_skin_r <= cfg_data[SKIN_W-1:0];
      end else if (cfg_index == CFG_ZERO_SPEED) begin
        cfg_limit_r <= cfg_data[LIM_W-1:0];
      end
    end
  end

  logic pipe_en;
  logic out_valid_r;

  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  // stage 0: fold the speed sign into the direction, form v and R
  logic                 sp_neg;
  logic        [W-1:0]  spm_c;
  logic signed [VW-1:0] dx_ext, dy_ext;
  side_t                side_c;
  logic        [W-1:0]  rsum_c;

  assign sp_neg = in_speed[W-1];
  assign spm_c  = sp_neg ? $unsigned(-in_speed) : $unsigned(in_speed);
  assign dx_ext = VW'(in_dir_x);
  assign dy_ext = VW'(in_dir_y);
  assign rsum_c = W'(in_mover_radius) + W'(in_target_radius);

  always_comb begin
    side_c.dx    = sp_neg ? -dx_ext : dx_ext;
    side_c.dy    = sp_neg ? -dy_ext : dy_ext;
    side_c.vx    = VW'(in_mover_x) - VW'(in_target_x);
    side_c.vy    = VW'(in_mover_y) - VW'(in_target_y);
    side_c.spm   = spm_c;
    side_c.nohit = (spm_c == '0) || (LCW'(spm_c) < LCW'(cfg_limit_r));
  end

  logic          st0_v_r;
  side_t         st0_side_r;
  logic [W-1:0]  st0_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st0_v_r <= 1'b0;
    end else if (pipe_en) begin
      st0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      st0_side_r <= side_c;
      st0_r_r    <= rsum_c;
    end
  end

  // stage 1: element products
  logic                   st1_v_r;
  side_t                  st1_side_r;
  logic signed [2*VW-1:0] st1_dxdx_r, st1_dydy_r, st1_dxvx_r, st1_dyvy_r;
  logic signed [2*VW-1:0] st1_vxvx_r, st1_vyvy_r;
  logic        [2*W-1:0]  st1_rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
    end else if (pipe_en) begin
      st1_v_r <= st0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      st1_side_r <= st0_side_r;
      st1_dxdx_r <= st0_side_r.dx * st0_side_r.dx;
      st1_dydy_r <= st0_side_r.dy * st0_side_r.dy;
      st1_dxvx_r <= st0_side_r.dx * st0_side_r.vx;
      st1_dyvy_r <= st0_side_r.dy * st0_side_r.vy;
      st1_vxvx_r <= st0_side_r.vx * st0_side_r.vx;
      st1_vyvy_r <= st0_side_r.vy * st0_side_r.vy;
      st1_rr_r   <= st0_r_r * st0_r_r;
    end
  end

  // stage 2: a = d.d, h = d.v, c = v.v - R*R
  logic                 st2_v_r;
  side_t                st2_side_r;
  logic        [AW-1:0] st2_a_r;
  logic signed [HW-1:0] st2_h_r;
  logic signed [CW-1:0] st2_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_v_r <= 1'b0;
    end else if (pipe_en) begin
      st2_v_r <= st1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      st2_side_r <= st1_side_r;
      st2_a_r    <= AW'(st1_dxdx_r + st1_dydy_r);
      st2_h_r    <= HW'(st1_dxvx_r) + HW'(st1_dyvy_r);
      st2_c_r    <= CW'(st1_vxvx_r) + CW'(st1_vyvy_r) - CW'($signed({1'b0, st1_rr_r}));
    end
  end

  // stage 3: magnitudes for the discriminant products
  logic                 st3_v_r;
  side_t                st3_side_r;
  side_t                st3_side_c;
  logic        [AW-1:0] st3_a_r;
  logic signed [HW-1:0] st3_h_r;
  logic        [HM-1:0] st3_hm_r;
  logic        [CM-1:0] st3_cm_r;
  logic                 st3_cneg_r;

  // drop a zero direction
  always_comb begin
    st3_side_c       = st2_side_r;
    st3_side_c.nohit = st2_side_r.nohit || (st2_a_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st3_v_r <= 1'b0;
    end else if (pipe_en) begin
      st3_v_r <= st2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      st3_side_r       <= st3_side_c;
      st3_a_r          <= st2_a_r;
      st3_h_r          <= st2_h_r;
      st3_hm_r         <= st2_h_r[HW-1] ? HM'($unsigned(-st2_h_r)) : HM'($unsigned(st2_h_r));
      st3_cm_r         <= st2_c_r[CW-1] ? CM'($unsigned(-st2_c_r)) : CM'($unsigned(st2_c_r));
      st3_cneg_r       <= st2_c_r[CW-1];
    end
  end

  // stage 4: partial products of h*h and a*|c|
  logic                    st4_v_r;
  side_t                   st4_side_r;
  logic        [AW-1:0]    st4_a_r;
  logic signed [HW-1:0]    st4_h_r;
  logic                    st4_cneg_r;
  logic [2*SP-1:0]         st4_hll_r;
  logic [SP+W-1:0]         st4_hlh_r;
  logic [2*W-1:0]          st4_hhh_r;
  logic [2*SP-1:0]         st4_all_r;
  logic [SP+W:0]           st4_alh_r;
  logic [W+SP-2:0]         st4_ahl_r;
  logic [2*W-1:0]          st4_ahh_r;
  logic [SP-1:0]           hl, al, cl;
  logic [W-1:0]            hh;
  logic [W-2:0]            ah;
  logic [W:0]              ch;

  assign hl = st3_hm_r[SP-1:0];
  assign hh = st3_hm_r[HM-1:SP];
  assign al = st3_a_r[SP-1:0];
  assign ah = st3_a_r[AW-1:SP];
  assign cl = st3_cm_r[SP-1:0];
  assign ch = st3_cm_r[CM-1:SP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st4_v_r <= 1'b0;
    end else if (pipe_en) begin
      st4_v_r <= st3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      st4_side_r <= st3_side_r;
      st4_a_r    <= st3_a_r;
      st4_h_r    <= st3_h_r;
      st4_cneg_r <= st3_cneg_r;
      st4_hll_r  <= hl * hl;
      st4_hlh_r  <= hl * hh;
      st4_hhh_r  <= hh * hh;
      st4_all_r  <= al * cl;
      st4_alh_r  <= al * ch;
      st4_ahl_r  <= ah * cl;
      st4_ahh_r  <= ah * ch;
    end
  end

  // stage 5: assemble h*h and a*|c|
  logic                 st5_v_r;
  side_t                st5_side_r;
  logic        [AW-1:0] st5_a_r;
  logic signed [HW-1:0] st5_h_r;
  logic                 st5_cneg_r;
  logic       [DMW-1:0] st5_hsq_r, st5_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st5_v_r <= 1'b0;
    end else if (pipe_en) begin
      st5_v_r <= st4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      st5_side_r <= st4_side_r;
      st5_a_r    <= st4_a_r;
      st5_h_r    <= st4_h_r;
      st5_cneg_r <= st4_cneg_r;
      st5_hsq_r  <= DMW'(st4_hll_r) + (DMW'(st4_hlh_r) << (SP + 1))
                  + (DMW'(st4_hhh_r) << (2 * SP));
      st5_ac_r   <= DMW'(st4_all_r) + (DMW'(st4_alh_r) << SP) + (DMW'(st4_ahl_r) << SP)
                  + (DMW'(st4_ahh_r) << (2 * SP));
    end
  end

  // stage 6: discriminant, then the root pipeline
  logic [DMW:0] dfull;
  side_t        sq0_side_c;

  assign dfull = st5_cneg_r ? {1'b0, st5_hsq_r} + {1'b0, st5_ac_r}
                            : {1'b0, st5_hsq_r} - {1'b0, st5_ac_r};

  // drop a negative discriminant
  always_comb begin
    sq0_side_c       = st5_side_r;
    sq0_side_c.nohit = st5_side_r.nohit || (!st5_cneg_r && dfull[DMW]);
  end

  logic                 sq_v_r    [NDIG+1];
  side_t                sq_side_r [NDIG+1];
  logic        [AW-1:0] sq_a_r    [NDIG+1];
  logic signed [HW-1:0] sq_h_r    [NDIG+1];
  logic       [RMW-1:0] sq_rem_r  [NDIG+1];
  logic       [RTW-1:0] sq_root_r [NDIG+1];
  logic       [DMW-1:0] sq_d_r    [NDIG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (pipe_en) begin
      sq_v_r[0] <= st5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_side_r[0]       <= sq0_side_c;
      sq_a_r[0]          <= st5_a_r;
      sq_h_r[0]          <= st5_h_r;
      sq_rem_r[0]        <= '0;
      sq_root_r[0]       <= '0;
      sq_d_r[0]          <= dfull[DMW-1:0];
    end
  end

  // one root digit per stage, top pair of radicand bits first
  for (genvar i = 0; i < NDIG; i++) begin : g_sqrt
    logic [RMW-1:0] cat;
    logic [RMW-1:0] trial;
    logic           ge;

    assign cat   = {sq_rem_r[i][RMW-3:0], sq_d_r[i][DMW-1 -: 2]};
    assign trial = RMW'({sq_root_r[i], 2'b01});
    assign ge    = cat >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[i+1] <= 1'b0;
      end else if (pipe_en) begin
        sq_v_r[i+1] <= sq_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        sq_side_r[i+1] <= sq_side_r[i];
        sq_a_r[i+1]    <= sq_a_r[i];
        sq_h_r[i+1]    <= sq_h_r[i];
        sq_rem_r[i+1]  <= ge ? cat - trial : cat;
        sq_root_r[i+1] <= {sq_root_r[i][RTW-2:0], ge};
      end
    end

    if (i < NDIG - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          sq_d_r[i+1] <= sq_d_r[i] << 2;
        end
      end
    end
  end

  // n1: t = -h - sqrt(D)
  logic                 n1_v_r;
  side_t                n1_side_r;
  logic        [AW-1:0] n1_a_r;
  logic signed [TW-1:0] n1_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_v_r <= 1'b0;
    end else if (pipe_en) begin
      n1_v_r <= sq_v_r[NDIG];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      n1_side_r <= sq_side_r[NDIG];
      n1_a_r    <= sq_a_r[NDIG];
      n1_t_r    <= -TW'(sq_h_r[NDIG]) - $signed(TW'(sq_root_r[NDIG]));
    end
  end

  // n2: numerator magnitude, then restoring division by a
  logic                dv_v_r    [QB+1];
  side_t               dv_side_r [QB+1];
  logic       [AW-1:0] dv_a_r    [QB+1];
  logic                dv_neg_r  [QB+1];
  logic       [NW-1:0] dv_rem_r  [QB+1];
  logic       [QB-1:0] dv_q_r    [QB+1];
  logic       [TM-1:0] tmag;

  assign tmag = n1_t_r[TW-1] ? TM'($unsigned(-n1_t_r)) : TM'($unsigned(n1_t_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (pipe_en) begin
      dv_v_r[0] <= n1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dv_side_r[0] <= n1_side_r;
      dv_a_r[0]    <= n1_a_r;
      dv_neg_r[0]  <= n1_t_r[TW-1];
      dv_rem_r[0]  <= {tmag, {F{1'b0}}};
      dv_q_r[0]    <= '0;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_sdiv
    logic [DVW-1:0] dsh;
    logic           ge;

    assign dsh = DVW'(dv_a_r[i]) << (QB - 1 - i);
    assign ge  = DVW'(dv_rem_r[i]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i+1] <= 1'b0;
      end else if (pipe_en) begin
        dv_v_r[i+1] <= dv_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dv_side_r[i+1] <= dv_side_r[i];
        dv_a_r[i+1]    <= dv_a_r[i];
        dv_neg_r[i+1]  <= dv_neg_r[i];
        dv_rem_r[i+1]  <= ge ? NW'(DVW'(dv_rem_r[i]) - dsh) : dv_rem_r[i];
        dv_q_r[i+1]    <= {dv_q_r[i][QB-2:0], ge};
      end
    end
  end

  // p1: floor quotient s; a remainder not below a means the quotient overflowed
  logic                 p1_v_r;
  side_t                p1_side_r;
  side_t                p1_side_c;
  logic signed [SW-1:0] p1_s_r;
  logic signed [SW-1:0] qx;
  logic                 q_ovf;
  logic                 q_rnz;

  assign qx    = $signed(SW'(dv_q_r[QB]));
  assign q_ovf = DVW'(dv_rem_r[QB]) >= DVW'(dv_a_r[QB]);
  assign q_rnz = dv_rem_r[QB] != '0;

  always_comb begin
    p1_side_c       = dv_side_r[QB];
    p1_side_c.nohit = dv_side_r[QB].nohit || q_ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (pipe_en) begin
      p1_v_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p1_side_r       <= p1_side_c;
      p1_s_r          <= dv_neg_r[QB] ? -(qx + $signed(SW'(q_rnz))) : qx;
    end
  end

  // p2: entry window -skin < s < speed
  logic                  p2_v_r;
  side_t                 p2_side_r;
  logic                  p2_hit_r;
  logic signed [SRW-1:0] p2_s_r;
  logic signed [SW-1:0]  s_lo, s_hi;

  assign s_lo = -$signed(SW'(cfg_skin_r));
  assign s_hi = $signed(SW'(p1_side_r.spm));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (pipe_en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p2_side_r <= p1_side_r;
      p2_hit_r  <= !p1_side_r.nohit && (p1_s_r > s_lo) && (p1_s_r < s_hi);
      p2_s_r    <= p1_s_r[SRW-1:0];
    end
  end

  // i0: normal products and the impact numerator
  logic                 i0_v_r;
  logic                 i0_hit_r;
  logic signed [VW-1:0] i0_vx_r, i0_vy_r;
  logic        [W-1:0]  i0_sp_r;
  logic signed [PW-1:0] i0_px_r, i0_py_r;
  logic                 i0_neg_r;
  logic       [INW-1:0] i0_num_r;
  logic      [SMAG-1:0] smag;

  assign smag = p2_s_r[SRW-1] ? SMAG'($unsigned(-p2_s_r)) : SMAG'($unsigned(p2_s_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i0_v_r <= 1'b0;
    end else if (pipe_en) begin
      i0_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      i0_hit_r <= p2_hit_r;
      i0_vx_r  <= p2_side_r.vx;
      i0_vy_r  <= p2_side_r.vy;
      i0_sp_r  <= p2_side_r.spm;
      i0_px_r  <= p2_side_r.dx * p2_s_r;
      i0_py_r  <= p2_side_r.dy * p2_s_r;
      i0_neg_r <= p2_s_r[SRW-1];
      i0_num_r <= {smag, {F{1'b0}}};
    end
  end

  // i1: contact normal, then restoring division by speed
  logic                id_v_r   [IQB+1];
  logic                id_hit_r [IQB+1];
  logic                id_neg_r [IQB+1];
  logic [W-1:0]        id_sp_r  [IQB+1];
  logic [INW-1:0]      id_rem_r [IQB+1];
  logic [IQB-1:0]      id_q_r   [IQB+1];
  logic signed [W-1:0] id_nx_r  [IQB+1];
  logic signed [W-1:0] id_ny_r  [IQB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_v_r[0] <= 1'b0;
    end else if (pipe_en) begin
      id_v_r[0] <= i0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      id_hit_r[0] <= i0_hit_r;
      id_neg_r[0] <= i0_neg_r;
      id_sp_r[0]  <= i0_sp_r;
      id_rem_r[0] <= i0_num_r;
      id_q_r[0]   <= '0;
      id_nx_r[0]  <= sat_w(NSW'(i0_px_r >>> F) + NSW'(i0_vx_r));
      id_ny_r[0]  <= sat_w(NSW'(i0_py_r >>> F) + NSW'(i0_vy_r));
    end
  end

  for (genvar i = 0; i < IQB; i++) begin : g_tdiv
    logic [IDW-1:0] dsh;
    logic           ge;

    assign dsh = IDW'(id_sp_r[i]) << (IQB - 1 - i);
    assign ge  = IDW'(id_rem_r[i]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        id_v_r[i+1] <= 1'b0;
      end else if (pipe_en) begin
        id_v_r[i+1] <= id_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        id_hit_r[i+1] <= id_hit_r[i];
        id_neg_r[i+1] <= id_neg_r[i];
        id_sp_r[i+1]  <= id_sp_r[i];
        id_rem_r[i+1] <= ge ? INW'(IDW'(id_rem_r[i]) - dsh) : id_rem_r[i];
        id_q_r[i+1]   <= {id_q_r[i][IQB-2:0], ge};
        id_nx_r[i+1]  <= id_nx_r[i];
        id_ny_r[i+1]  <= id_ny_r[i];
      end
    end
  end

  // output register: floor and saturate the impact time
  logic                t_ovf;
  logic                t_rnz;
  logic [W:0]          t_mag;
  logic signed [W-1:0] t_val;

  assign t_ovf = IDW'(id_rem_r[IQB]) >= IDW'(id_sp_r[IQB]);
  assign t_rnz = id_rem_r[IQB] != '0;
  assign t_mag = (W+1)'(id_q_r[IQB]) + (W+1)'(t_rnz);

  always_comb begin
    if (id_neg_r[IQB]) begin
      if (t_ovf || (t_mag > {2'b01, {(W-1){1'b0}}})) begin
        t_val = WMIN;
      end else begin
        t_val = W'((W+1)'(0) - t_mag);
      end
    end else begin
      if (t_ovf || id_q_r[IQB][W-1]) begin
        t_val = WMAX;
      end else begin
        t_val = $signed(id_q_r[IQB][W-1:0]);
      end
    end
  end

  logic                out_hit_r;
  logic signed [W-1:0] out_impact_time_r, out_normal_x_r, out_normal_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= id_v_r[IQB];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_hit_r         <= id_hit_r[IQB];
      out_impact_time_r <= id_hit_r[IQB] ? t_val : '0;
      out_normal_x_r    <= id_hit_r[IQB] ? id_nx_r[IQB] : '0;
      out_normal_y_r    <= id_hit_r[IQB] ? id_ny_r[IQB] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_impact_time = out_impact_time_r;
  assign out_normal_x    = out_normal_x_r;
  assign out_normal_y    = out_normal_y_r;

endmodule

// File: rtl/core/swc_checker.sv
// ----------------------------------------------------------------------------
// swc_checker: port-level checks for the swept circle collision core
// Watches the result channel and the input handshake over time; attached to the core by bind.
// ----------------------------------------------------------------------------
module swc_checker #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_hit,
  input logic signed [COORD_WIDTH-1:0] out_impact_time,
  input logic signed [COORD_WIDTH-1:0] out_normal_x,
  input logic signed [COORD_WIDTH-1:0] out_normal_y
);

  localparam logic signed [COORD_WIDTH-1:0] T_ONE = COORD_WIDTH'(1) << FRAC_BITS;

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit)
      && $stable(out_impact_time) && $stable(out_normal_x) && $stable(out_normal_y))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_impact_time == '0 && out_normal_x == '0
      && out_normal_y == '0)
    else $error("miss carries nonzero payload");

  // entry lies before the end of travel, so time stays below one
  a_time_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_impact_time < T_ONE)
    else $error("impact time not below one");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result must block new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("input taken while result stalled");

endmodule

bind swept_circle_collision_core swc_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_swc_checker (.*);
